### rtl/core/mmcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcg_pkg
// Check kinds, polynomials and the per-byte fold and run-layout functions
// shared by the multi-mode check generator.
// ----------------------------------------------------------------------------
package mmcg_pkg;

    typedef enum logic [2:0] {
        KIND_CRC16_LO  = 3'd0,
        KIND_CRC16_HI  = 3'd1,
        KIND_CRC8      = 3'd2,
        KIND_SUM       = 3'd3,
        KIND_XOR       = 3'd4,
        KIND_CRC32_LE  = 3'd5,
        KIND_CRC32_MSB = 3'd6,
        KIND_NONE      = 3'd7
    } t_kind;

    localparam logic [31:0] POLY_CRC16_REFL = 32'h0000_A001;
    localparam logic [31:0] POLY_CRC8       = 32'h0000_0007;
    localparam logic [31:0] POLY_CRC32_REFL = 32'hEDB8_8320;
    localparam logic [31:0] POLY_CRC32_MSB  = 32'h04C1_1DB7;
    localparam logic [31:0] INIT_CRC16      = 32'h0000_FFFF;
    localparam logic [31:0] INIT_CRC32      = 32'hFFFF_FFFF;

    // finished check handed from the fold stage to the emitter
    typedef struct packed {
        logic        load;
        logic [31:0] value;
        t_kind       kind;
    } t_run_load;

    function automatic logic [31:0] mmcg_init_value(input t_kind kind);
        logic [31:0] v;
        case (kind)
            KIND_CRC16_LO, KIND_CRC16_HI:   v = INIT_CRC16;
            KIND_CRC32_LE, KIND_CRC32_MSB:  v = INIT_CRC32;
            default:                        v = 32'h0;
        endcase
        return v;
    endfunction

    // one byte folded into the running check, eight bit steps unrolled for the CRC kinds
    function automatic logic [31:0] mmcg_fold_byte(input t_kind kind,
                                                   input logic [31:0] acc,
                                                   input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        case (kind)
            KIND_CRC16_LO, KIND_CRC16_HI: begin
                r = {16'h0, acc[15:0] ^ {8'h0, b}};
                for (int i = 0; i < 8; i++) begin
                    r = r[0] ? ((r >> 1) ^ POLY_CRC16_REFL) : (r >> 1);
                end
                r = {16'h0, r[15:0]};
            end
            KIND_CRC8: begin
                r = {24'h0, acc[7:0] ^ b};
                for (int i = 0; i < 8; i++) begin
                    r = r[7] ? ({24'h0, r[6:0], 1'b0} ^ POLY_CRC8)
                             : {24'h0, r[6:0], 1'b0};
                end
            end
            KIND_SUM: begin
                r = {24'h0, acc[7:0] + b};
            end
            KIND_XOR: begin
                r = {24'h0, acc[7:0] ^ b};
            end
            KIND_CRC32_LE: begin
                r = acc ^ {24'h0, b};
                for (int i = 0; i < 8; i++) begin
                    r = r[0] ? ((r >> 1) ^ POLY_CRC32_REFL) : (r >> 1);
                end
            end
            KIND_CRC32_MSB: begin
                r = acc ^ {b, 24'h0};
                for (int i = 0; i < 8; i++) begin
                    r = r[31] ? ({r[30:0], 1'b0} ^ POLY_CRC32_MSB) : {r[30:0], 1'b0};
                end
            end
            default: begin
                r = acc;
            end
        endcase
        return r;
    endfunction

    // number of check bytes in a run
    function automatic logic [2:0] mmcg_run_len(input t_kind kind);
        logic [2:0] n;
        case (kind)
            KIND_CRC16_LO, KIND_CRC16_HI:         n = 3'd2;
            KIND_CRC8, KIND_SUM, KIND_XOR:        n = 3'd1;
            KIND_CRC32_LE, KIND_CRC32_MSB:        n = 3'd4;
            default:                              n = 3'd0;
        endcase
        return n;
    endfunction

    // check byte at a given place in the run
    function automatic logic [7:0] mmcg_run_byte(input t_kind kind,
                                                 input logic [31:0] v,
                                                 input logic [1:0] pos);
        logic [31:0] s;
        case (kind)
            KIND_CRC16_LO:  s = (pos == 2'd0) ? v : (v >> 8);
            KIND_CRC16_HI:  s = (pos == 2'd0) ? (v >> 8) : v;
            KIND_CRC32_LE:  s = (~v) >> {pos, 3'b000};
            KIND_CRC32_MSB: s = v >> {~pos, 3'b000};
            default:        s = v;
        endcase
        return s[7:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/mmcg_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcg_fold
// Input word register and running check register; folds one byte per cycle
// unless stalled; hands the finished check to the emitter on the last byte.
// ----------------------------------------------------------------------------
module mmcg_fold (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mmcg_pkg::t_kind   i_kind,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_message,
    input  wire logic              i_run_free,
    output mmcg_pkg::t_run_load    o_run
);
    import mmcg_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_check;
    logic        r_mid;

    logic        advance;
    logic        accept;
    logic [31:0] base;
    logic [31:0] n_check;

    // a last word waits only if it has a run to emit and the emitter is busy
    assign advance = r_in_valid &&
                     (!r_in_last || (i_kind == KIND_NONE) || i_run_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept = i_in_valid && !o_in_stall;

    assign base    = r_mid ? r_check : mmcg_init_value(i_kind);
    assign n_check = mmcg_fold_byte(i_kind, base, r_in_byte);

    assign o_run.load  = advance && r_in_last && (i_kind != KIND_NONE);
    assign o_run.value = n_check;
    assign o_run.kind  = i_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_check    <= 32'h0;
            r_mid      <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_check <= n_check;
                r_mid   <= !r_in_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_message;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mmcg_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcg_emit
// Run register that holds one finished check and sends it out as one to
// four check bytes in the order of its kind.
// ----------------------------------------------------------------------------
module mmcg_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mmcg_pkg::t_run_load   i_run,
    output logic                       o_run_free,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_check_byte,
    output logic [1:0]                 o_byte_position,
    output logic                       o_last_of_run
);
    import mmcg_pkg::*;

    logic        r_valid;
    logic [31:0] r_value;
    t_kind       r_kind;
    logic [1:0]  r_pos;

    logic        take;
    logic        last;

    assign last = ({1'b0, r_pos} == (mmcg_run_len(r_kind) - 3'd1));
    assign take = r_valid && !i_out_stall;
    assign o_run_free = !r_valid || (take && last);

    assign o_out_valid     = r_valid;
    assign o_check_byte    = mmcg_run_byte(r_kind, r_value, r_pos);
    assign o_byte_position = r_pos;
    assign o_last_of_run   = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else begin
            if (i_run.load && o_run_free) begin
                r_valid <= 1'b1;
                r_pos   <= 2'd0;
            end else if (take && last) begin
                r_valid <= 1'b0;
                r_pos   <= 2'd0;
            end else if (take) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.load && o_run_free) begin
            r_value <= i_run.value;
            r_kind  <= i_run.kind;
        end
    end

endmodule
`default_nettype wire

### rtl/core/multi_mode_check_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_mode_check_generator
// Message byte stream in, check bytes (CRC-16, CRC-8, sum, XOR, CRC-32) out.
// ----------------------------------------------------------------------------
// Input words carry one message byte and an end-of-message flag; a word is
// taken when i_in_valid is high and o_in_stall low. Each output word carries
// one check byte, its place in the run and a last-of-run flag; it is taken
// when o_out_valid is high and i_out_stall low.
// The check kind is written through the cfg channel (always ready); write it
// only while the block is idle, which the block itself does not enforce.
// Throughput: one message byte per cycle through the input register and the
// byte-wide fold logic. A finished check of n bytes (one, two or four) leaves
// at one byte per cycle from the run register unless stalled; a final byte
// that arrives while the previous run drains waits in the input register.
// The final message byte is folded from the input register into the run
// register, and the first check byte is valid once the run register is loaded.
// Reset clears the kind to CRC-16 low byte first, drops any pending word and
// run, and starts a new message with the next byte.
// A stall on the output holds the run; the input keeps taking bytes until a
// further final byte needs the run register.
// ----------------------------------------------------------------------------
module multi_mode_check_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_check_byte,
    output logic [1:0]       o_byte_position,
    output logic             o_last_of_run
);
    import mmcg_pkg::*;

    t_kind     r_kind;
    t_run_load run;
    logic      run_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_CRC16_LO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_kind <= t_kind'(i_cfg_data);
        end
    end

    mmcg_fold u_fold (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (r_kind),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_run_free       (run_free),
        .o_run            (run)
    );

    mmcg_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_run           (run),
        .o_run_free      (run_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_check_byte    (o_check_byte),
        .o_byte_position (o_byte_position),
        .o_last_of_run   (o_last_of_run)
    );

    // input holds back only while a finished run cannot get into the emitter
    a_stall_needs_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !run_free)
        else $error("input stalled with run register free");

    // a run never ends before its last byte is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> o_out_valid)
        else $error("run dropped before its last byte");

    // check bytes of a run go out at consecutive positions
    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=>
            (o_byte_position == $past(o_byte_position) + 2'd1))
        else $error("byte position skipped");

    // a new run is only loaded when the emitter can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run.load && !run_free) |-> o_in_stall)
        else $error("run loaded into busy emitter");

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode check generator: message bytes are
// pushed through every check kind, and each check word that comes back is
// compared with a local prediction of the running check and its byte order.
// ----------------------------------------------------------------------------
module tb;
    import mmcg_pkg::*;

    localparam logic [31:0] CRC16_POLY     = 32'h0000_A001;
    localparam logic [31:0] CRC8_POLY      = 32'h0000_0007;
    localparam logic [31:0] CRC32_POLY_REF = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_POLY_MSB = 32'h04C1_1DB7;
    localparam logic [31:0] CRC16_SEED     = 32'h0000_FFFF;
    localparam logic [31:0] CRC32_SEED     = 32'hFFFF_FFFF;

    localparam int unsigned LATENCY_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] check_byte;
        logic [1:0] position;
        logic       last;
    } check_word_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_data_byte = '0;
    logic       i_end_of_message = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_check_byte;
    logic [1:0] o_byte_position;
    logic       o_last_of_run;

    // predicted state of the block
    t_kind       model_kind = KIND_CRC16_LO;
    logic [31:0] running_check = '0;
    logic        in_message = 1'b0;
    check_word_t pending_checks[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic [3:0]  hold_reqs = '0;
    logic [3:0]  hold_served = '0;
    int unsigned hold_left = 0;

    multi_mode_check_generator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_check_byte     (o_check_byte),
        .o_byte_position  (o_byte_position),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_out
        check_word_t got;
        check_word_t want;
        got = '{o_check_byte, o_byte_position, o_last_of_run};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_checks.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("unexpected check word: byte %h pos %0d last %b",
                             got.check_byte, got.position, got.last);
                end
                error_count <= error_count + 1;
            end else begin
                want = pending_checks.pop_front();
                if (got != want) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("check word mismatch: expected byte %h pos %0d last %b",
                                 want.check_byte, want.position, want.last);
                        $display("                     got byte %h pos %0d last %b",
                                 got.check_byte, got.position, got.last);
                    end
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // offer one message byte, wait for it to be taken, then predict its checks
    task automatic send_byte(input logic [7:0] b, input logic eom);
        logic [31:0] acc;
        logic [7:0]  seq [4];
        int          n;
        int          k;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= b;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);

        if (!in_message) begin
            case (model_kind)
                KIND_CRC16_LO, KIND_CRC16_HI:   running_check = CRC16_SEED;
                KIND_CRC32_LE, KIND_CRC32_MSB:  running_check = CRC32_SEED;
                default:                        running_check = '0;
            endcase
        end
        // the register carries over between kinds, cut to the current width
        case (model_kind)
            KIND_CRC16_LO, KIND_CRC16_HI: begin
                acc = {16'h0, running_check[15:0] ^ {8'h00, b}};
                repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC16_POLY) : (acc >> 1);
            end
            KIND_CRC8: begin
                acc = {24'h0, running_check[7:0] ^ b};
                repeat (8) begin
                    acc = acc[7] ? (((acc << 1) ^ CRC8_POLY) & 32'hFF)
                                 : ((acc << 1) & 32'hFF);
                end
            end
            KIND_SUM:       acc = {24'h0, running_check[7:0] + b};
            KIND_XOR:       acc = {24'h0, running_check[7:0] ^ b};
            KIND_CRC32_LE: begin
                acc = running_check ^ {24'h0, b};
                repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC32_POLY_REF) : (acc >> 1);
            end
            KIND_CRC32_MSB: begin
                acc = running_check ^ {b, 24'h0};
                repeat (8) acc = acc[31] ? ((acc << 1) ^ CRC32_POLY_MSB) : (acc << 1);
            end
            default:        acc = running_check;
        endcase
        running_check = acc;
        in_message = !eom;

        if (eom) begin
            n = 0;
            case (model_kind)
                KIND_CRC16_LO: begin
                    seq[0] = acc[7:0];
                    seq[1] = acc[15:8];
                    n = 2;
                end
                KIND_CRC16_HI: begin
                    seq[0] = acc[15:8];
                    seq[1] = acc[7:0];
                    n = 2;
                end
                KIND_CRC8, KIND_SUM, KIND_XOR: begin
                    seq[0] = acc[7:0];
                    n = 1;
                end
                KIND_CRC32_LE: begin
                    acc = ~acc;
                    for (k = 0; k < 4; k++) seq[k] = acc[8*k +: 8];
                    n = 4;
                end
                KIND_CRC32_MSB: begin
                    for (k = 0; k < 4; k++) seq[k] = acc[24 - 8*k +: 8];
                    n = 4;
                end
                default: n = 0;
            endcase
            for (k = 0; k < n; k++) begin
                pending_checks.push_back(check_word_t'{seq[k], k[1:0], (k == n - 1)});
            end
        end
    endtask

    task automatic write_kind(input t_kind k);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_kind = k;
    endtask

    // no word in flight: all checks back and the input register folded
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_checks.size() != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_kind();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // single-byte message in each kind, the unused one too
    task automatic test_every_kind();
        int k;
        for (k = 0; k < 8; k++) begin
            wait_idle();
            write_kind(t_kind'(k[2:0]));
            send_byte(k[0] ? 8'hFF : 8'h00, 1'b1);
        end
    endtask

    task automatic test_unused_kind();
        wait_idle();
        write_kind(KIND_NONE);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hFF, 1'b1);
        // the final byte above must still have closed the message
        wait_idle();
        write_kind(KIND_SUM);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_kind_change_mid_message();
        wait_idle();
        write_kind(KIND_CRC32_LE);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        wait_idle();
        write_kind(KIND_CRC8);
        send_byte(8'hBE, 1'b0);
        wait_idle();
        write_kind(KIND_CRC16_HI);
        send_byte(8'hEF, 1'b0);
        wait_idle();
        write_kind(KIND_CRC32_MSB);
        send_byte(8'h01, 1'b1);
    endtask

    // output held off while four-byte runs keep coming, so the input backs up
    task automatic test_output_hold_off();
        int i;
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_kind(KIND_CRC32_LE);
        hold_reqs <= hold_reqs + 1'b1;
        for (i = 0; i < 40; i++) send_byte(8'($urandom), ($urandom_range(3) != 0));
        wait_idle();
    endtask

    task automatic test_random_messages(input int unsigned idle_pct,
                                        input int unsigned stall_pct,
                                        input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        sent = 0;
        wait_idle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_kind(t_kind'($urandom_range(7)));
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) len = $urandom_range(24, 1);
            else len = $urandom_range(5, 1);
            for (i = 0; i < len; i++) begin
                send_byte(8'($urandom), (i == len - 1));
                sent++;
                if (i != len - 1 && $urandom_range(29) == 0) begin
                    wait_idle();
                    write_kind(t_kind'($urandom_range(7)));
                end
            end
            if ($urandom_range(7) == 0) begin
                wait_idle();
                write_kind(t_kind'($urandom_range(7)));
            end else if ($urandom_range(11) == 0) begin
                // sender pauses until the block has emptied
                wait_idle();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_kind();
        test_every_kind();
        test_unused_kind();
        test_kind_change_mid_message();
        test_output_hold_off();
        test_random_messages(0, 0, 75);
        test_random_messages(55, 0, 75);
        test_random_messages(0, 55, 75);
        test_random_messages(36, 36, 75);
        wait_idle();
        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/core/mmcg_pkg.sv
rtl/core/mmcg_fold.sv
rtl/core/mmcg_emit.sv
rtl/core/multi_mode_check_generator.sv
bench/tb.sv
